>>> sv/sbe_pkg.sv
`default_nettype none

package sbe_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;

    localparam int WORD_W      = 64;
    localparam int DEPTH_OUT_W = 5;
    localparam int S_TDATA_W   = 2 * WORD_W;
    localparam int M_TDATA_W   = 72;

    typedef enum logic [2:0] {
        OP_PUSH  = 3'd0,
        OP_PRINT = 3'd1,
        OP_READ  = 3'd2,
        OP_ADD   = 3'd3,
        OP_STOP  = 3'd4,
        OP_SWAP  = 3'd5,
        OP_POP   = 3'd6,
        OP_DUP   = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_UNDER = 2'd1,
        FAULT_OVER  = 2'd2
    } t_fault;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic latch;     // capture the request
        logic exec;      // run the instruction on the stack
        logic fill;      // reload second-of-stack from memory
        logic load_out;  // move the result into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_fill;
    } t_stat;

endpackage

`default_nettype wire

>>> sv/sbe_ctrl.sv
`default_nettype none

module sbe_ctrl
    import sbe_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    input  wire t_stat i_stat,
    output t_cmd      o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = i_stat.need_fill ? ST_FILL : ST_DONE;
            end
            ST_FILL: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd         = '0;
        s_axis_tready = 1'b0;
        n_out_valid   = r_out_valid && !m_axis_tready;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                o_cmd.latch   = s_axis_tvalid;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            ST_FILL: begin
                o_cmd.fill = 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;

endmodule

`default_nettype wire

>>> sv/sbe_datapath.sv
`default_nettype none

module sbe_datapath
    import sbe_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_stat                      o_stat,
    input  wire logic [2:0]            i_action,
    input  wire logic [WORD_W-1:0]     i_immediate,
    input  wire logic [WORD_W-1:0]     i_read_value,
    output logic                       o_print_valid,
    output logic [WORD_W-1:0]          o_print_value,
    output logic                       o_halted,
    output logic [1:0]                 o_fault,
    output logic [DEPTH_OUT_W-1:0]     o_depth_now
);

    // latched request
    t_op               r_op;
    logic [WORD_W-1:0] r_imm;
    logic [WORD_W-1:0] r_rd;

    // top two entries live in registers, the rest in memory at their own index
    logic [WORD_W-1:0] r_top, n_top;
    logic [WORD_W-1:0] r_second, n_second;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_stopped, n_stopped;

    logic [WORD_W-1:0] mem [STACK_DEPTH];
    logic [WORD_W-1:0] r_rdata;
    logic              mem_we;
    logic [CNT_W-1:0]  wr_cnt;
    logic [CNT_W-1:0]  rd_cnt;

    // pending result
    logic              r_res_pv, n_res_pv;
    logic [WORD_W-1:0] r_res_pval, n_res_pval;
    t_fault            r_res_fault, n_res_fault;

    // output register
    logic                   r_out_pv;
    logic [WORD_W-1:0]      r_out_pval;
    logic                   r_out_halted;
    logic [1:0]             r_out_fault;
    logic [DEPTH_OUT_W-1:0] r_out_depth;
    logic [CNT_W+DEPTH_OUT_W-1:0] depth_ext;

    logic has1, has2, has3, full;
    logic push_en;
    logic [WORD_W-1:0] push_val;

    assign has1 = r_count >= CNT_W'(1);
    assign has2 = r_count >= CNT_W'(2);
    assign has3 = r_count >= CNT_W'(3);
    assign full = r_count == CNT_W'(STACK_DEPTH);

    assign wr_cnt = r_count - CNT_W'(2);
    assign rd_cnt = r_count - CNT_W'(3);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op  <= t_op'(i_action);
            r_imm <= i_immediate;
            r_rd  <= i_read_value;
        end
    end

    // instruction execution
    always_comb begin
        n_top       = r_top;
        n_second    = r_second;
        n_count     = r_count;
        n_stopped   = r_stopped;
        n_res_pv    = 1'b0;
        n_res_pval  = '0;
        n_res_fault = FAULT_NONE;
        push_en     = 1'b0;
        push_val    = r_imm;
        o_stat.need_fill = 1'b0;

        if (!r_stopped) begin
            case (r_op)
                OP_PUSH: begin
                    push_val = r_imm;
                    if (full) n_res_fault = FAULT_OVER;
                    else      push_en     = 1'b1;
                end
                OP_READ: begin
                    push_val = r_rd;
                    if (full) n_res_fault = FAULT_OVER;
                    else      push_en     = 1'b1;
                end
                OP_DUP: begin
                    push_val = r_top;
                    if (!has1)     n_res_fault = FAULT_UNDER;
                    else if (full) n_res_fault = FAULT_OVER;
                    else           push_en     = 1'b1;
                end
                OP_PRINT, OP_POP: begin
                    if (!has1) begin
                        n_res_fault = FAULT_UNDER;
                    end else begin
                        if (r_op == OP_PRINT) begin
                            n_res_pv   = 1'b1;
                            n_res_pval = r_top;
                        end
                        n_top            = r_second;
                        n_count          = r_count - CNT_W'(1);
                        o_stat.need_fill = has3;
                    end
                end
                OP_ADD: begin
                    if (!has2) begin
                        n_res_fault = FAULT_UNDER;
                    end else begin
                        n_top            = r_top + r_second;
                        n_count          = r_count - CNT_W'(1);
                        o_stat.need_fill = has3;
                    end
                end
                OP_SWAP: begin
                    if (!has2) begin
                        n_res_fault = FAULT_UNDER;
                    end else begin
                        n_top    = r_second;
                        n_second = r_top;
                    end
                end
                OP_STOP: begin
                    n_stopped = 1'b1;
                end
                default: begin
                    n_res_fault = FAULT_NONE;
                end
            endcase
        end

        if (push_en) begin
            n_top    = push_val;
            n_second = r_top;
            n_count  = r_count + CNT_W'(1);
        end
    end

    assign mem_we = i_cmd.exec && push_en && has2;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[wr_cnt[ADDR_W-1:0]] <= r_second;
        r_rdata <= mem[rd_cnt[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_stopped <= 1'b0;
        end else if (i_cmd.exec) begin
            r_count   <= n_count;
            r_stopped <= n_stopped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_top       <= n_top;
            r_second    <= n_second;
            r_res_pv    <= n_res_pv;
            r_res_pval  <= n_res_pval;
            r_res_fault <= n_res_fault;
        end else if (i_cmd.fill) begin
            r_second <= r_rdata;
        end
    end

    assign depth_ext = {{DEPTH_OUT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_pv     <= r_res_pv;
            r_out_pval   <= r_res_pval;
            r_out_halted <= r_stopped;
            r_out_fault  <= r_res_fault;
            r_out_depth  <= depth_ext[DEPTH_OUT_W-1:0];
        end
    end

    assign o_print_valid = r_out_pv;
    assign o_print_value = r_out_pval;
    assign o_halted      = r_out_halted;
    assign o_fault       = r_out_fault;
    assign o_depth_now   = r_out_depth;

endmodule

`default_nettype wire

>>> sv/stack_bytecode_executor.sv
`default_nettype none

// Channel  Dir  Fields (low bit up)
// -------  ---  ----------------------------------------------------------
// s_axis   in   tuser[2:0] action; tdata[63:0] immediate,
//               tdata[127:64] read_value
// m_axis   out  tuser[0] print_valid; tdata[63:0] print_value,
//               tdata[64] halted, tdata[66:65] fault, tdata[71:67] depth_now
//
// One instruction request at a time: accept, execute, hand-off; a refill
// step before hand-off for print, pop and add with three or more stack entries,
// where the registered stack-memory read refills the second-of-stack register.
// The output register lets the next request be accepted while a result waits.
// Synchronous active-low reset clears depth, halt flag and output valid;
// stack contents are not cleared. A stalled m_axis holds the hand-off state.

module stack_bytecode_executor
    import sbe_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,   // immediate, read_value
    input  wire logic [2:0]            s_axis_tuser,   // action
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]       m_axis_tdata,   // print_value, halted, fault,
                                                       // depth_now
    output logic                       m_axis_tuser    // print_valid
);

    t_cmd  cmd;
    t_stat stat;

    logic [WORD_W-1:0]      print_value;
    logic                   halted;
    logic [1:0]             fault;
    logic [DEPTH_OUT_W-1:0] depth_now;

    sbe_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    sbe_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_action      (s_axis_tuser),
        .i_immediate   (s_axis_tdata[WORD_W-1:0]),
        .i_read_value  (s_axis_tdata[2*WORD_W-1:WORD_W]),
        .o_print_valid (m_axis_tuser),
        .o_print_value (print_value),
        .o_halted      (halted),
        .o_fault       (fault),
        .o_depth_now   (depth_now)
    );

    assign m_axis_tdata = {depth_now, fault, halted, print_value};

endmodule

`default_nettype wire
